>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the merge RTL.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)

`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hw/rtl/kwhm_pkg.sv
// Shared types and constants for the k-way heap merge.
// No dependencies; imported by kwhm_sift and k_way_heap_merge.
`timescale 1ns / 1ps

package kwhm_pkg;

   // Default sizes
   localparam int DEF_MAX_LISTS = 8;
   localparam int DEF_MAX_LEN   = 64;

   // Element and channel widths
   localparam int ELEM_W      = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 40;
   localparam int SRC_OUT_W   = 3;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int CNT_CFG_W   = 4;
   localparam int LEN_CFG_W   = 7;

   localparam logic signed [ELEM_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   // Register indexes and reset values
   localparam logic [CSR_ADDR_W-1:0] CSR_LIST_COUNT  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_LIST_LENGTH = 1'b1;
   localparam logic [CNT_CFG_W-1:0]  RST_LIST_COUNT  = 4'd8;
   localparam logic [LEN_CFG_W-1:0]  RST_LIST_LENGTH = 7'd64;

   // Command codes carried in req_tuser
   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_POP   = 2'd2
   } cmd_type;

   // Heap unit operations
   typedef enum logic [1:0] {
      HOP_WRITE     = 2'd0,
      HOP_PEEK      = 2'd1,
      HOP_SIFT_AT   = 2'd2,
      HOP_SIFT_NODE = 2'd3
   } heap_op_type;

   typedef struct packed {
      logic        start;
      heap_op_type op;
   } heap_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } heap_sts_type;

endpackage

>>> hw/rtl/k_way_heap_merge.sv
// K-way merge of sorted lists through a binary min-heap: top level.
// Depends on kwhm_pkg, kwhm_sift and assert_macros.svh.
// Load writes the list store and answers. Pop peeks the root, reads the next element of its list
// and sifts the new root down; an exhausted pop or unknown command answers without the heap.
// Build reads each list head into the heap, then does one node read and sift per inner heap node.
// One word in flight; a new request is taken only once the last word has gone to the output register.
// Synchronous reset clears control and the pop count and restores the register defaults; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module k_way_heap_merge import kwhm_pkg::*; #(
   parameter int MAX_LISTS = DEF_MAX_LISTS,
   parameter int MAX_LEN   = DEF_MAX_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // list_index[2:0], position[8:3], element_value[40:9]
   input  logic [1:0]            req_tuser,  // command[1:0]
   // Response channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // merged_value[31:0], source_list[34:32]
   output logic                  rsp_tuser,  // status[0]
   output logic                  rsp_tlast,  // final_flag
   // Register writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LIST_W = $clog2(MAX_LISTS);
   localparam int LEN_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int NEXT_W = $clog2(MAX_LEN + 1);
   localparam int CNT_W  = $clog2(MAX_LISTS + 1);
   localparam int TOT_W  = $clog2(MAX_LISTS * MAX_LEN + 1);
   localparam int ADDR_W = LIST_W + LEN_W;
   localparam int NODE_W = ELEM_W + LIST_W + NEXT_W;

   typedef struct packed {
      logic [NEXT_W-1:0]        next;
      logic [LIST_W-1:0]        src;
      logic signed [ELEM_W-1:0] value;
   } node_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BMUL,
      ST_BREAD,
      ST_BFILL,
      ST_HSIFT,
      ST_HWAIT,
      ST_PPEEK,
      ST_PWAIT,
      ST_PREAD,
      ST_PSIFT,
      ST_PDONE,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [CNT_CFG_W-1:0]     list_count_ff, list_count_in;
   logic [LEN_CFG_W-1:0]     list_length_ff, list_length_in;
   logic [CNT_W-1:0]         live_count_ff, live_count_in;
   logic [NEXT_W-1:0]        live_length_ff, live_length_in;
   logic [TOT_W-1:0]         total_ff, total_in;
   logic [TOT_W-1:0]         pop_count_ff, pop_count_in;
   logic [LIST_W-1:0]        fill_ff, fill_in;
   logic [LIST_W-1:0]        hidx_ff, hidx_in;
   node_type                 root_ff, root_in;
   logic signed [ELEM_W-1:0] res_value_ff, res_value_in;
   logic [SRC_OUT_W-1:0]     res_src_ff, res_src_in;
   logic                     res_status_ff, res_status_in;
   logic                     res_final_ff, res_final_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic [SRC_OUT_W-1:0]     rsp_src_ff, rsp_src_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic                     rsp_final_ff, rsp_final_in;

   logic [ELEM_W-1:0]        list_mem [2**ADDR_W];
   logic signed [ELEM_W-1:0] list_rd_ff;
   logic                     list_we;
   logic [ADDR_W-1:0]        list_wa, list_ra;

   logic                     req_fire;
   cmd_type                  req_cmd;
   logic [2:0]               req_list;
   logic [5:0]               req_pos;
   logic [ELEM_W-1:0]        req_value;
   logic [CNT_W-1:0]         count_sat;
   logic [NEXT_W-1:0]        length_sat;

   heap_ctl_type             heap_ctl;
   heap_sts_type             heap_sts;
   logic [LIST_W-1:0]        heap_idx;
   node_type                 heap_node;
   logic [NODE_W-1:0]        heap_out;
   node_type                 heap_rd;

   // Unpack the request word
   assign req_cmd   = cmd_type'(req_tuser);
   assign req_list  = req_tdata[2:0];
   assign req_pos   = req_tdata[8:3];
   assign req_value = req_tdata[40:9];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign heap_rd    = node_type'(heap_out);

   // Clamp register values into the supported range at build
   assign count_sat = (list_count_ff == '0) ? CNT_W'(1) :
                      (32'(list_count_ff) > 32'(MAX_LISTS)) ? CNT_W'(MAX_LISTS) :
                      CNT_W'(list_count_ff);
   assign length_sat = (list_length_ff == '0) ? NEXT_W'(1) :
                       (32'(list_length_ff) > 32'(MAX_LEN)) ? NEXT_W'(MAX_LEN) :
                       NEXT_W'(list_length_ff);

   // List store access: load writes, build reads heads, pop reads the next element
   assign list_we = req_fire && (req_cmd == CMD_LOAD) && (32'(req_list) < 32'(MAX_LISTS)) &&
                    (32'(req_pos) < 32'(MAX_LEN));
   assign list_wa = {LIST_W'(req_list), LEN_W'(req_pos)};
   assign list_ra = (state_ff == ST_BREAD) ? {fill_ff, LEN_W'(0)} :
                                             {root_ff.src, LEN_W'(root_ff.next)};

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_wa] <= req_value;
      end
      list_rd_ff <= list_mem[list_ra];
   end

   // Command sequencer
   always_comb begin
      state_in       = state_ff;
      list_count_in  = list_count_ff;
      list_length_in = list_length_ff;
      live_count_in  = live_count_ff;
      live_length_in = live_length_ff;
      total_in       = total_ff;
      pop_count_in   = pop_count_ff;
      fill_in        = fill_ff;
      hidx_in        = hidx_ff;
      root_in        = root_ff;
      res_value_in   = res_value_ff;
      res_src_in     = res_src_ff;
      res_status_in  = res_status_ff;
      res_final_in   = res_final_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_final_in   = rsp_final_ff;
      heap_ctl       = '{start: 1'b0, op: HOP_WRITE};
      heap_idx       = '0;
      heap_node      = root_ff;

      // Register writes
      if (csr_we) begin
         unique case (csr_addr)
            CSR_LIST_COUNT:  list_count_in  = csr_wdata[CNT_CFG_W-1:0];
            CSR_LIST_LENGTH: list_length_in = csr_wdata[LEN_CFG_W-1:0];
            default: ;
         endcase
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_value_in  = '0;
               res_src_in    = '0;
               res_status_in = 1'b0;
               res_final_in  = 1'b0;
               case (req_cmd)
                  CMD_LOAD: begin
                     state_in = ST_FINISH;
                  end
                  CMD_BUILD: begin
                     live_count_in  = count_sat;
                     live_length_in = length_sat;
                     state_in       = ST_BMUL;
                  end
                  CMD_POP: begin
                     if ((pop_count_ff >= total_ff) || (live_count_ff == '0)) begin
                        res_status_in = 1'b1;
                        state_in      = ST_FINISH;
                     end else begin
                        state_in = ST_PPEEK;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_BMUL: begin
            total_in     = TOT_W'(live_count_ff * live_length_ff);
            pop_count_in = '0;
            fill_in      = '0;
            state_in     = ST_BREAD;
         end
         ST_BREAD: begin
            state_in = ST_BFILL;
         end
         ST_BFILL: begin
            // Seed one heap entry with the head of its list
            heap_ctl  = '{start: 1'b1, op: HOP_WRITE};
            heap_idx  = fill_ff;
            heap_node = '{next: NEXT_W'(1), src: fill_ff, value: list_rd_ff};
            fill_in   = fill_ff + 1'b1;
            if ((32'(fill_ff) + 32'd1) == 32'(live_count_ff)) begin
               hidx_in  = LIST_W'((live_count_ff - 1'b1) >> 1);
               state_in = ST_HSIFT;
            end else begin
               state_in = ST_BREAD;
            end
         end
         ST_HSIFT: begin
            heap_ctl = '{start: 1'b1, op: HOP_SIFT_AT};
            heap_idx = hidx_ff;
            state_in = ST_HWAIT;
         end
         ST_HWAIT: begin
            if (heap_sts.done) begin
               if (hidx_ff == '0) begin
                  pop_count_in = '0;
                  state_in     = ST_FINISH;
               end else begin
                  hidx_in  = hidx_ff - 1'b1;
                  state_in = ST_HSIFT;
               end
            end
         end
         ST_PPEEK: begin
            heap_ctl = '{start: 1'b1, op: HOP_PEEK};
            heap_idx = '0;
            state_in = ST_PWAIT;
         end
         ST_PWAIT: begin
            // Root arrives: it is the answer
            if (heap_sts.done) begin
               root_in      = heap_rd;
               res_value_in = heap_rd.value;
               res_src_in   = SRC_OUT_W'(heap_rd.src);
               res_final_in = (({1'b0, pop_count_ff} + 1'b1) == {1'b0, total_ff});
               pop_count_in = pop_count_ff + 1'b1;
               state_in     = ST_PREAD;
            end
         end
         ST_PREAD: begin
            state_in = ST_PSIFT;
         end
         ST_PSIFT: begin
            // Refill the root from its list, or park it at the maximum
            heap_ctl = '{start: 1'b1, op: HOP_SIFT_NODE};
            heap_idx = '0;
            if (root_ff.next < live_length_ff) begin
               heap_node = '{next: root_ff.next + 1'b1, src: root_ff.src, value: list_rd_ff};
            end else begin
               heap_node = '{next: root_ff.next, src: root_ff.src, value: INT_MAX};
            end
            state_in = ST_PDONE;
         end
         ST_PDONE: begin
            if (heap_sts.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hand the word to the output register when it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_src_in    = res_src_ff;
               rsp_status_in = res_status_ff;
               rsp_final_in  = res_final_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, counters and registered outputs
   always_ff @(posedge clock) begin
      root_ff       <= root_in;
      res_value_ff  <= res_value_in;
      res_src_ff    <= res_src_in;
      res_status_ff <= res_status_in;
      res_final_ff  <= res_final_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_status_ff <= rsp_status_in;
      rsp_final_ff  <= rsp_final_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         list_count_ff  <= RST_LIST_COUNT;
         list_length_ff <= RST_LIST_LENGTH;
         live_count_ff  <= '0;
         live_length_ff <= NEXT_W'(1);
         total_ff       <= '0;
         pop_count_ff   <= '0;
         fill_ff        <= '0;
         hidx_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         list_count_ff  <= list_count_in;
         list_length_ff <= list_length_in;
         live_count_ff  <= live_count_in;
         live_length_ff <= live_length_in;
         total_ff       <= total_in;
         pop_count_ff   <= pop_count_in;
         fill_ff        <= fill_in;
         hidx_ff        <= hidx_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   kwhm_sift #(
      .MAX_LISTS (MAX_LISTS),
      .MAX_LEN   (MAX_LEN)
   ) u_sift (
      .clock        (clock),
      .reset        (reset),
      .ctl_i        (heap_ctl),
      .idx_i        (heap_idx),
      .node_i       (NODE_W'(heap_node)),
      .live_count_i (live_count_ff),
      .sts_o        (heap_sts),
      .node_o       (heap_out)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_src_ff, rsp_value_ff});
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_final_ff;

   `ASSERT_IMPLY(a_ready_heap_idle, clock, reset, req_tready, !heap_sts.busy, "request taken while heap busy")
   `ASSERT_ALWAYS(a_pop_bound, clock, reset, pop_count_ff <= total_ff, "pop count passed the total")
   `ASSERT_IMPLY(a_final_is_valid, clock, reset, rsp_valid_ff && rsp_final_ff, !rsp_status_ff, "last element flagged on an exhausted pop")

endmodule

>>> hw/rtl/kwhm_sift.sv
// Heap entry memory and the shared sift-down compare unit.
// Depends on kwhm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kwhm_sift import kwhm_pkg::*; #(
   parameter int MAX_LISTS = DEF_MAX_LISTS,
   parameter int MAX_LEN   = DEF_MAX_LEN
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  heap_ctl_type                           ctl_i,
   input  logic [$clog2(MAX_LISTS)-1:0]           idx_i,
   input  logic [ELEM_W+$clog2(MAX_LISTS)+$clog2(MAX_LEN+1)-1:0] node_i,
   input  logic [$clog2(MAX_LISTS+1)-1:0]         live_count_i,
   output heap_sts_type                           sts_o,
   output logic [ELEM_W+$clog2(MAX_LISTS)+$clog2(MAX_LEN+1)-1:0] node_o
);

   localparam int IDX_W  = $clog2(MAX_LISTS);
   localparam int NEXT_W = $clog2(MAX_LEN + 1);
   localparam int KID_W  = IDX_W + 2;

   typedef struct packed {
      logic [NEXT_W-1:0]        next;
      logic [IDX_W-1:0]         src;
      logic signed [ELEM_W-1:0] value;
   } node_type;

   typedef enum logic [2:0] {
      H_IDLE,
      H_READ,
      H_GRAB,
      H_CHILD,
      H_CMP
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   node_type          node_ff, node_in;
   logic              peek_ff, peek_in;
   logic              done_ff, done_in;
   node_type          rd_a_ff, rd_b_ff;
   node_type          heap_mem [2**IDX_W];

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   node_type          wr_data;
   logic [IDX_W-1:0]  addr_a, addr_b;
   logic [KID_W-1:0]  kid_l, kid_r, live_ext;
   logic              l_ok, r_ok, l_lt, r_lt_n, r_lt_l;

   // Child indexes and range checks
   assign kid_l    = KID_W'({cur_ff, 1'b1});
   assign kid_r    = kid_l + 1'b1;
   assign live_ext = KID_W'(live_count_i);
   assign l_ok     = kid_l < live_ext;
   assign r_ok     = kid_r < live_ext;

   // Read addresses: the node itself while reading, else both children
   assign addr_a = (state_ff == H_READ) ? cur_ff : kid_l[IDX_W-1:0];
   assign addr_b = kid_r[IDX_W-1:0];

   // Shared compare unit: strict less-than, left child first
   assign l_lt   = rd_a_ff.value < node_ff.value;
   assign r_lt_n = r_ok && (rd_b_ff.value < node_ff.value);
   assign r_lt_l = r_ok && (rd_b_ff.value < rd_a_ff.value);

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      node_in  = node_ff;
      peek_in  = peek_ff;
      done_in  = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = cur_ff;
      wr_data  = node_ff;
      unique case (state_ff)
         H_IDLE: begin
            if (ctl_i.start) begin
               unique case (ctl_i.op)
                  HOP_WRITE: begin
                     wr_en   = 1'b1;
                     wr_addr = idx_i;
                     wr_data = node_type'(node_i);
                  end
                  HOP_PEEK: begin
                     cur_in   = idx_i;
                     peek_in  = 1'b1;
                     state_in = H_READ;
                  end
                  HOP_SIFT_AT: begin
                     cur_in   = idx_i;
                     peek_in  = 1'b0;
                     state_in = H_READ;
                  end
                  HOP_SIFT_NODE: begin
                     cur_in   = idx_i;
                     node_in  = node_type'(node_i);
                     state_in = H_CHILD;
                  end
               endcase
            end
         end
         H_READ: begin
            state_in = H_GRAB;
         end
         H_GRAB: begin
            node_in = rd_a_ff;
            if (peek_ff) begin
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_CHILD;
            end
         end
         H_CHILD: begin
            // Leaf: drop the held node here
            if (!l_ok) begin
               wr_en    = 1'b1;
               done_in  = 1'b1;
               state_in = H_IDLE;
            end else begin
               state_in = H_CMP;
            end
         end
         H_CMP: begin
            if (l_lt) begin
               wr_en    = 1'b1;
               wr_data  = r_lt_l ? rd_b_ff : rd_a_ff;
               cur_in   = r_lt_l ? kid_r[IDX_W-1:0] : kid_l[IDX_W-1:0];
               state_in = H_CHILD;
            end else if (r_lt_n) begin
               wr_en    = 1'b1;
               wr_data  = rd_b_ff;
               cur_in   = kid_r[IDX_W-1:0];
               state_in = H_CHILD;
            end else begin
               wr_en    = 1'b1;
               done_in  = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      node_ff <= node_in;
      peek_ff <= peek_in;
      if (reset) begin
         state_ff <= H_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // Heap entry memory, one write and two registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[addr_a];
      rd_b_ff <= heap_mem[addr_b];
   end

   assign sts_o  = '{busy: (state_ff != H_IDLE), done: done_ff};
   assign node_o = node_ff;

   `ASSERT_IMPLY(a_start_when_idle, clock, reset, ctl_i.start, state_ff == H_IDLE, "heap op started while busy")
   `ASSERT_IMPLY(a_cmp_has_left, clock, reset, state_ff == H_CMP, l_ok, "compare without a left child")
   `ASSERT_IMPLY(a_live_stable, clock, reset, state_ff != H_IDLE, $stable(live_count_i), "heap size changed during an operation")

endmodule

>>> bench/tb.sv
// Self-checking bench for the k-way heap merge: directed steps, then random merges.
// Depends on kwhm_pkg and the k_way_heap_merge top level; the checker predicts every word a step does not type in.
`timescale 1ns / 1ps

module tb;
   import kwhm_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int LISTS       = DEF_MAX_LISTS;
   localparam int LEN         = DEF_MAX_LEN;
   localparam int ITEM_TARGET = 1650;

   // One merge result word, split into its fields
   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic [SRC_OUT_W-1:0]     src;
      logic                     status;
      logic                     final_flag;
   } merge_word_t;

   typedef struct {
      logic signed [ELEM_W-1:0] value;
      logic [2:0]               src;
      logic [6:0]               next;
   } heap_node_t;

   // Directed step: a register write or a request word
   typedef struct {
      bit                is_csr;
      logic [1:0]        sel;          // command, or register index on a register step
      logic [2:0]        list_idx;
      logic [5:0]        pos;
      logic [ELEM_W-1:0] value;        // element, or register value on a register step
      bit                fixed;        // expected word typed in here, not predicted
      bit                fixed_status;
   } step_row_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // list_index[2:0], position[8:3], element_value[40:9]
   logic [1:0]            req_tuser = '0;  // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // merged_value[31:0], source_list[34:32]
   logic                  rsp_tuser;       // status[0]
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Predictor state
   logic [ELEM_W-1:0] store_mem [LISTS*LEN];
   heap_node_t        heap_mem [LISTS];
   int unsigned       pop_done;
   int unsigned       live_lists;
   int unsigned       live_len;
   logic [3:0]        reg_count;
   logic [6:0]        reg_length;

   merge_word_t expected_q [$];
   int          words_sent = 0;
   int          rsp_count = 0;
   int          mismatch_count = 0;
   int          idle_phase = 0;
   bit          row_fixed = 1'b0;
   bit          row_fixed_status = 1'b0;
   bit          store_full = 1'b0;
   int          send_gap_pct [3] = '{14, 64, 0};
   int          recv_gap_pct [3] = '{64, 14, 0};

   step_row_t steps [23] = '{
      '{1'b1, CSR_LIST_COUNT,  3'd0, 6'd0,  32'd3,        1'b0, 1'b0},
      '{1'b1, CSR_LIST_LENGTH, 3'd0, 6'd0,  32'd2,        1'b0, 1'b0},
      '{1'b0, CMD_LOAD,        3'd0, 6'd0,  32'h8000_0000, 1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd0, 6'd1,  32'd5,        1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd1, 6'd0,  32'd5,        1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd1, 6'd1,  32'h7FFF_FFFF, 1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd2, 6'd0,  32'd0,        1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd2, 6'd1,  32'hFFFF_FFFF, 1'b1, 1'b0},
      '{1'b0, CMD_LOAD,        3'd7, 6'd63, 32'hAAAA_5555, 1'b1, 1'b0},
      '{1'b0, CMD_UNKNOWN,     3'd7, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0},
      '{1'b0, CMD_BUILD,       3'd0, 6'd0,  32'd0,        1'b1, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd7, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b1},
      '{1'b1, CSR_LIST_COUNT,  3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b1, CSR_LIST_LENGTH, 3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_BUILD,       3'd0, 6'd0,  32'd0,        1'b1, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b0, 1'b0},
      '{1'b0, CMD_POP,         3'd0, 6'd0,  32'd0,        1'b1, 1'b1}
   };

   k_way_heap_merge u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Hard stop in case the block hangs
   initial begin
      #(10_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("mismatch at %0t ns: %s got %0h want %0h", $time, what, got, want);
   endtask

   // Sink the node at 'at' until neither child is strictly smaller; left child wins ties
   function automatic void sift_heap(int unsigned at);
      int unsigned l;
      int unsigned r;
      int unsigned s;
      heap_node_t  t;
      while (1'b1) begin
         l = 2 * at + 1;
         r = 2 * at + 2;
         s = at;
         if (l < live_lists && heap_mem[l].value < heap_mem[at].value) s = l;
         if (r < live_lists && heap_mem[r].value < heap_mem[s].value) s = r;
         if (s == at) return;
         t = heap_mem[at];
         heap_mem[at] = heap_mem[s];
         heap_mem[s] = t;
         at = s;
      end
   endfunction

   // Apply one request word to the predictor and return the word it should produce
   function automatic merge_word_t predict_merge(input logic [1:0] cmd, input logic [2:0] li,
                                                 input logic [5:0] pos,
                                                 input logic [ELEM_W-1:0] val);
      merge_word_t w;
      heap_node_t  root;
      int unsigned total;
      w.value = '0;
      w.src = '0;
      w.status = 1'b0;
      w.final_flag = 1'b0;
      case (cmd)
         CMD_LOAD: begin
            store_mem[{li, pos}] = val;
         end
         CMD_BUILD: begin
            live_lists = (reg_count < 1) ? 1 : (reg_count > LISTS) ? LISTS : reg_count;
            live_len = (reg_length < 1) ? 1 : (reg_length > LEN) ? LEN : reg_length;
            for (int i = 0; i < int'(live_lists); i++)
               heap_mem[i] = '{store_mem[i*LEN], 3'(i), 7'd1};
            for (int i = int'((live_lists - 1) / 2); i >= 0; i--)
               sift_heap(i);
            pop_done = 0;
         end
         CMD_POP: begin
            total = live_lists * live_len;
            if (pop_done >= total || live_lists == 0) begin
               w.status = 1'b1;
            end else begin
               root = heap_mem[0];
               w.value = root.value;
               w.src = root.src;
               w.final_flag = (pop_done + 1 == total);
               pop_done++;
               // refill from the same list, or park the slot at the top of the range
               if (root.next < live_len) begin
                  root.value = store_mem[root.src*LEN + root.next];
                  root.next++;
               end else begin
                  root.value = INT_MAX;
               end
               heap_mem[0] = root;
               sift_heap(0);
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   // Check response words, then predict each accepted request word
   always @(posedge clock) begin : monitor
      merge_word_t want;
      merge_word_t got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[31:0];
            got.src = rsp_tdata[34:32];
            got.status = rsp_tuser;
            got.final_flag = rsp_tlast;
            rsp_count++;
            if (expected_q.size() == 0) begin
               report_mismatch("word with nothing expected", got.value, '0);
            end else begin
               want = expected_q.pop_front();
               if (got.value !== want.value)
                  report_mismatch("merged_value", got.value, want.value);
               if (got.src !== want.src)
                  report_mismatch("source_list", got.src, want.src);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.final_flag !== want.final_flag)
                  report_mismatch("final_flag", got.final_flag, want.final_flag);
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_merge(req_tuser, req_tdata[2:0], req_tdata[8:3], req_tdata[40:9]);
            if (row_fixed) begin
               want.value = '0;
               want.src = '0;
               want.status = row_fixed_status;
               want.final_flag = 1'b0;
            end
            expected_q.push_back(want);
         end
      end
   end

   // Receiver stalls at random according to the current idling phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_gap_pct[idle_phase]);
   end

   // Present one request word, idling first at random, and hold until accepted
   task automatic send_word(input logic [1:0] cmd, input logic [2:0] li, input logic [5:0] pos,
                            input logic [ELEM_W-1:0] val, input bit fixed = 1'b0,
                            input bit fixed_status = 1'b0);
      idle_phase = (words_sent < 550) ? 0 : (words_sent < 1100) ? 1 : 2;
      while ($urandom_range(0, 99) < send_gap_pct[idle_phase]) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, val, pos, li};
      row_fixed <= fixed;
      row_fixed_status <= fixed_status;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Drain every outstanding word, then write one register
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (rsp_count < words_sent) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      if (idx == CSR_LIST_COUNT) reg_count = val[3:0];
      else reg_length = val[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One merge: set sizes, load lists where cheap, build, then pop
   task automatic run_merge(input int count_val, input int length_val);
      int                       eff_lists;
      int                       eff_len;
      int                       total;
      int                       pops;
      int                       change_at;
      longint                   nxt;
      logic signed [ELEM_W-1:0] cur;
      write_reg(CSR_LIST_COUNT, count_val);
      write_reg(CSR_LIST_LENGTH, length_val);
      eff_lists = count_val & 15;
      eff_lists = (eff_lists < 1) ? 1 : (eff_lists > LISTS) ? LISTS : eff_lists;
      eff_len = length_val & 127;
      eff_len = (eff_len < 1) ? 1 : (eff_len > LEN) ? LEN : eff_len;
      total = eff_lists * eff_len;

      // Load fresh lists; a big merge reuses what is already in the store
      if (!store_full || total <= 96) begin
         for (int l = 0; l < eff_lists; l++) begin
            case ($urandom_range(0, 7))
               0: cur = 32'sh8000_0000;
               1: cur = INT_MAX - $urandom_range(0, 40);
               default: cur = $urandom;
            endcase
            for (int p = 0; p < eff_len; p++) begin
               if ($urandom_range(0, 29) == 0)
                  send_word($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_LOAD,
                            $urandom, $urandom, $urandom);
               send_word(CMD_LOAD, l, p, cur);
               if ($urandom_range(0, 9) == 0) begin
                  cur = $urandom;
               end else begin
                  nxt = longint'(cur) + $urandom_range(0, 1 << $urandom_range(0, 20));
                  cur = (nxt > longint'(INT_MAX)) ? INT_MAX : nxt[31:0];
               end
            end
         end
      end
      send_word(CMD_BUILD, $urandom, $urandom, $urandom);

      if (!store_full) pops = total + 1;
      else if (total <= 96) pops = total + $urandom_range(0, 2);
      else pops = $urandom_range(16, 48);
      change_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, pops - 1) : -1;
      for (int k = 0; k < pops; k++) begin
         // new register values mid-merge must not touch the running merge
         if (k == change_at) begin
            write_reg(CSR_LIST_COUNT, $urandom_range(0, 15));
            write_reg(CSR_LIST_LENGTH, $urandom_range(0, 127));
         end
         if ($urandom_range(0, 29) == 0)
            send_word($urandom_range(0, 1) ? CMD_UNKNOWN : CMD_LOAD,
                      $urandom, $urandom, $urandom);
         send_word(CMD_POP, $urandom, $urandom, $urandom);
      end
      store_full = 1'b1;
   endtask

   initial begin : stimulus
      int count_val;
      int length_val;
      foreach (store_mem[i]) store_mem[i] = '0;
      pop_done = 0;
      live_lists = 0;
      live_len = 1;
      reg_count = RST_LIST_COUNT;
      reg_length = RST_LIST_LENGTH;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed steps
      foreach (steps[n]) begin
         if (steps[n].is_csr)
            write_reg(steps[n].sel[CSR_ADDR_W-1:0], steps[n].value[CSR_DATA_W-1:0]);
         else
            send_word(steps[n].sel, steps[n].list_idx, steps[n].pos, steps[n].value,
                      steps[n].fixed, steps[n].fixed_status);
      end

      // Largest merge first, with out-of-range register values; it fills the whole store
      run_merge(15, 127);
      while (words_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: count_val = 0;
            1: count_val = $urandom_range(9, 127);
            2: count_val = LISTS;
            3: count_val = 1;
            default: count_val = $urandom_range(1, LISTS);
         endcase
         case ($urandom_range(0, 9))
            0: length_val = 0;
            1: length_val = $urandom_range(65, 127);
            2: length_val = LEN;
            3: length_val = 1;
            default: length_val = $urandom_range(2, 12);
         endcase
         run_merge(count_val, length_val);
      end

      // Drain and let any stray word show up
      req_tvalid <= 1'b0;
      while (rsp_count < words_sent) @(posedge clock);
      repeat (40) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("expected words never arrived", expected_q.size(), 0);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/kwhm_pkg.sv
hw/rtl/kwhm_sift.sv
hw/rtl/k_way_heap_merge.sv
bench/tb.sv
